@@ rtl/core/dtwe_pkg.sv @@
// Shared types and constants for the DTW distance block.
package dtwe_pkg;

	localparam int COEFF_W  = 16;
	localparam int DIST_W   = 32;
	localparam int FRAMES_W = 9;
	localparam int STATUS_W = 2;
	localparam int FDIM_W   = 5;
	localparam int DIV_NW   = 33;
	localparam int OUT_W    = 56;

	localparam logic [FDIM_W-1:0] FDIM_RESET = 5'd13;
	localparam logic [DIST_W-1:0] COST_SAT   = 32'hFFFF_FFFF;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_UNUSABLE = 2'd1,
		STAT_TOO_LONG = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		DIV_TEST,
		DIV_TRAIN,
		DIV_FINAL
	} div_opnd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_T,
		ST_DIV_R,
		ST_CHECK,
		ST_MAC,
		ST_SQRT,
		ST_UPD,
		ST_FDIV,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic      store;
		logic      div_start;
		div_opnd_t div_opnd;
		logic      latch_tq;
		logic      latch_rq;
		logic      check;
		logic      mac_run;
		logic      sqrt_start;
		logic      cell_upd;
		logic      latch_dist;
		logic      load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic grid_ok;
		logic mac_done;
		logic sqrt_done;
		logic grid_last;
		logic acc_sat;
	} dp_stat_t;

endpackage

@@ rtl/core/dtw_euclidean_distance.sv @@
// Top level of the DTW distance block with Euclidean frame cost.
// Input channel s_axis: one coefficient word per cycle; tuser = 0 for a test
// coefficient, 1 for a train coefficient; tlast marks the final coefficient.
// A test sequence closed by tlast is kept and reused for every train sequence;
// the next test word after that starts a new test sequence.
// Load words are taken back to back, one per cycle, while the block is idle.
// The train word with tlast starts the grid compute; s_axis_tready stays low
// until the result word is placed in the output register. Each grid cell
// runs the squared-difference accumulator once per coefficient and then the
// two-bit-per-cycle square root; the frame counts and the final average each
// use a serial divider. An error result skips the grid and the final average.
// Output channel m_axis: one result word per train sequence. The output
// register holds it while m_axis_tready is low; the block keeps taking load
// words meanwhile and only waits if a second result is ready.
// Reset clears the counts, the closed flag, the control state and sets
// feature_dim to 13; stores are not cleared.
module dtw_euclidean_distance #(
	parameter int MAX_FRAMES = 256,
	parameter int MAX_DIM    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dtwe_pkg::FDIM_W-1:0]   cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,  // coeff
	input  logic                          s_axis_tuser,  // action
	input  logic                          s_axis_tlast,  // last_of_sequence
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [dtwe_pkg::OUT_W-1:0]    m_axis_tdata   // distance, test_frames,
	                                                     // train_frames, status
);
	import dtwe_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	dtwe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_action (s_axis_tuser),
		.s_last   (s_axis_tlast),
		.m_tready (m_axis_tready),
		.stat     (stat),
		.cmd      (cmd),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid)
	);

	dtwe_dp #(
		.MAX_FRAMES (MAX_FRAMES),
		.MAX_DIM    (MAX_DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.action    (s_axis_tuser),
		.coeff     (s_axis_tdata),
		.last      (s_axis_tlast),
		.out_word  (m_axis_tdata)
	);

	// a compute start blocks the next input word
	a_start_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast) |=> !s_axis_tready)
		else $error("input taken right after compute start");

	// an error result carries a zero distance
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[51:50] != STAT_OK) |-> (m_axis_tdata[31:0] == '0))
		else $error("error result with nonzero distance");

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && m_axis_tvalid) |-> m_axis_tready)
		else $error("result word overwritten");
endmodule

@@ rtl/core/dtwe_div.sv @@
// Restoring divider, one quotient bit per cycle.
module dtwe_div #(
	parameter int NW = 33,
	parameter int VW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [VW-1:0] rem
);
	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   quo_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   dvs_q;
	logic [VW:0]     rem2;
	logic            ge;

	assign rem2 = {rem_q, quo_q[NW-1]};
	assign ge   = rem2 >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? VW'(rem2 - {1'b0, dvs_q}) : rem2[VW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

@@ rtl/core/dtwe_sqrt.sv @@
// Digit-by-digit integer square root, rounded to nearest, two radicand bits per cycle.
module dtwe_sqrt #(
	parameter int SW = 36
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [SW-1:0] rad,
	output logic          done,
	output logic [SW/2:0] root
);
	localparam int HW   = SW / 2;
	localparam int RW   = HW + 2;
	localparam int CNTW = $clog2(HW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [SW-1:0]   rad_q;
	logic [RW-1:0]   rem_q;
	logic [HW-1:0]   root_q;
	logic [RW+1:0]   rem2;
	logic [RW+1:0]   trial;
	logic            ge;

	assign rem2  = {rem_q, rad_q[SW-1:SW-2]};
	assign trial = (RW+2)'({root_q, 2'b01});
	assign ge    = rem2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(HW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SW-3:0], 2'b00};
			rem_q  <= ge ? RW'(rem2 - trial) : RW'(rem2);
			root_q <= {root_q[HW-2:0], ge};
		end
	end

	// round up when the remainder exceeds the floor root
	assign root = {1'b0, root_q} + (HW+1)'(rem_q > RW'(root_q));
	assign done = done_q;
endmodule

@@ rtl/core/dtwe_ctrl.sv @@
// Sequencer for loading, grid compute and result handoff.
module dtwe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_action,
	input  logic                s_last,
	input  logic                m_tready,
	input  dtwe_pkg::dp_stat_t  stat,
	output dtwe_pkg::ctrl_cmd_t cmd,
	output logic                s_tready,
	output logic                m_tvalid
);
	import dtwe_pkg::*;

	state_t state_q, state_d;
	logic   out_full_q;
	logic   can_load;

	assign can_load = !out_full_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid && s_action && s_last) state_d = ST_DIV_T;
			ST_DIV_T:  if (stat.div_done) state_d = ST_DIV_R;
			ST_DIV_R:  if (stat.div_done) state_d = ST_CHECK;
			ST_CHECK:  state_d = stat.grid_ok ? ST_MAC : ST_RESULT;
			ST_MAC:    if (stat.mac_done) state_d = ST_SQRT;
			ST_SQRT:   if (stat.sqrt_done) state_d = ST_UPD;
			ST_UPD: begin
				if (!stat.grid_last) state_d = ST_MAC;
				else if (stat.acc_sat) state_d = ST_RESULT;
				else state_d = ST_FDIV;
			end
			ST_FDIV:   if (stat.div_done) state_d = ST_RESULT;
			ST_RESULT: if (can_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.div_opnd = DIV_TEST;
		s_tready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.store     = s_tvalid;
				cmd.div_start = s_tvalid && s_action && s_last;
			end
			ST_DIV_T: begin
				cmd.latch_tq  = stat.div_done;
				cmd.div_start = stat.div_done;
				cmd.div_opnd  = DIV_TRAIN;
			end
			ST_DIV_R:  cmd.latch_rq = stat.div_done;
			ST_CHECK:  cmd.check = 1'b1;
			ST_MAC: begin
				cmd.mac_run    = 1'b1;
				cmd.sqrt_start = stat.mac_done;
			end
			ST_SQRT:   ;
			ST_UPD: begin
				cmd.cell_upd  = 1'b1;
				cmd.div_start = stat.grid_last && !stat.acc_sat;
				cmd.div_opnd  = DIV_FINAL;
			end
			ST_FDIV:   cmd.latch_dist = stat.div_done;
			ST_RESULT: cmd.load_out = can_load;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_full_q <= 1'b1;
			else if (m_tready) out_full_q <= 1'b0;
		end
	end

	assign m_tvalid = out_full_q;
endmodule

@@ rtl/core/dtwe_dp.sv @@
// Datapath: sequence stores, cost row, local cost and accumulation, result word.
module dtwe_dp #(
	parameter int MAX_FRAMES = 256,
	parameter int MAX_DIM    = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dtwe_pkg::ctrl_cmd_t             cmd,
	output dtwe_pkg::dp_stat_t              stat,
	input  logic                            cfg_we,
	input  logic [dtwe_pkg::FDIM_W-1:0]     cfg_wdata,
	input  logic                            action,
	input  logic [dtwe_pkg::COEFF_W-1:0]    coeff,
	input  logic                            last,
	output logic [dtwe_pkg::OUT_W-1:0]      out_word
);
	import dtwe_pkg::*;

	localparam int DEPTH = MAX_FRAMES * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 2);
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int FW    = $clog2(MAX_FRAMES + 1);
	localparam int JW    = $clog2(MAX_FRAMES);
	localparam int NVW   = $clog2(2 * MAX_FRAMES + 1);
	localparam int VW    = (NVW > DW) ? NVW : DW;
	localparam int SUMW  = 32 + $clog2(MAX_DIM);
	localparam int SW    = SUMW + (SUMW % 2);
	localparam int KW    = $clog2(MAX_DIM + 3);

	// configuration and sequence counts
	logic [FDIM_W-1:0] fdim_q;
	logic [DW-1:0]     dim;
	logic [CW-1:0]     cap;
	logic [CW-1:0]     test_cnt_q, train_cnt_q;
	logic              test_closed_q;
	logic [CW-1:0]     cur, nxt;
	logic              wr_ok;

	// stores
	logic [COEFF_W-1:0] test_mem  [DEPTH];
	logic [COEFF_W-1:0] train_mem [DEPTH];
	logic [DIST_W-1:0]  cost_row  [MAX_FRAMES];

	// grid walk
	logic [FW-1:0]     i_q, j_q;
	logic [CW-1:0]     ti_base_q, tj_base_q;
	logic [CW-1:0]     t_sum, r_sum;
	logic [KW-1:0]     k_q;
	logic              issue;
	logic              v1_s1, v2_s2;
	logic [COEFF_W-1:0] rd_t_s1, rd_r_s1;
	logic signed [COEFF_W:0]     diff;
	logic signed [2*COEFF_W+1:0] sq;
	logic [31:0]       prod_s2;
	logic [SUMW-1:0]   sum_q;
	logic [DIST_W-1:0] above_q, left_q, diag_q;
	logic [DIST_W-1:0] best, acc, lc;
	logic [DIST_W:0]   acc_sum;
	logic [SW/2:0]     root;
	logic              sqrt_done;
	logic              i_last, j_last;

	// division and result
	logic              div_done;
	logic [DIV_NW-1:0] div_nd, div_q;
	logic [VW-1:0]     div_dv, div_r;
	logic [FW:0]       n_frames;
	logic [FW-1:0]     q_capped;
	logic [FW-1:0]     tf_q, rf_q;
	logic              t_rem_q, r_rem_q;
	status_t           status_c, status_q;
	logic [DIST_W-1:0] dist_q;
	logic [DIST_W-1:0] out_dist_q;
	logic [FRAMES_W-1:0] out_tf_q, out_rf_q;
	status_t           out_status_q;

	always_comb begin
		if (fdim_q == '0) dim = DW'(1);
		else if (int'(fdim_q) > MAX_DIM) dim = DW'(MAX_DIM);
		else dim = DW'(fdim_q);
	end

	assign cap = CW'(MAX_FRAMES) * CW'(dim);

	// a test word after a closed sequence starts a new one
	assign cur   = action ? train_cnt_q : (test_closed_q ? '0 : test_cnt_q);
	assign wr_ok = cur < cap;
	assign nxt   = wr_ok ? cur + CW'(1) : ((cur == cap) ? cap + CW'(1) : cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fdim_q        <= FDIM_RESET;
			test_cnt_q    <= '0;
			train_cnt_q   <= '0;
			test_closed_q <= 1'b0;
		end else begin
			if (cfg_we) fdim_q <= cfg_wdata;
			if (cmd.store) begin
				if (!action) begin
					test_cnt_q    <= nxt;
					test_closed_q <= last;
				end else begin
					train_cnt_q <= nxt;
				end
			end
			if (cmd.load_out) train_cnt_q <= '0;
		end
	end

	assign t_sum = ti_base_q + CW'(k_q);
	assign r_sum = tj_base_q + CW'(k_q);
	assign issue = cmd.mac_run && (k_q < KW'(dim));

	always_ff @(posedge clk) begin
		if (cmd.store && wr_ok && !action) test_mem[cur[AW-1:0]] <= coeff;
		if (cmd.store && wr_ok && action) train_mem[cur[AW-1:0]] <= coeff;
		rd_t_s1 <= test_mem[t_sum[AW-1:0]];
		rd_r_s1 <= train_mem[r_sum[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_run && k_q == '0) above_q <= cost_row[j_q[JW-1:0]];
		if (cmd.cell_upd) cost_row[j_q[JW-1:0]] <= acc;
	end

	assign diff = {rd_t_s1[COEFF_W-1], rd_t_s1} - {rd_r_s1[COEFF_W-1], rd_r_s1};
	assign sq   = diff * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			k_q   <= cmd.mac_run ? k_q + KW'(1) : '0;
			v1_s1 <= issue;
			v2_s2 <= v1_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= sq[31:0];
		if (!cmd.mac_run) sum_q <= '0;
		else if (v2_s2) sum_q <= sum_q + SUMW'(prod_s2);
	end

	dtwe_sqrt #(.SW(SW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.rad    (SW'(sum_q)),
		.done   (sqrt_done),
		.root   (root)
	);

	assign lc = DIST_W'(root);

	always_comb begin
		best = COST_SAT;
		if (i_q != '0 && above_q < best) best = above_q;
		if (j_q != '0 && left_q < best) best = left_q;
		if (i_q != '0 && j_q != '0 && diag_q < best) best = diag_q;
		acc_sum = {1'b0, lc} + {1'b0, best};
		if (i_q == '0 && j_q == '0) acc = '0;
		else if (acc_sum[DIST_W]) acc = COST_SAT;
		else acc = acc_sum[DIST_W-1:0];
	end

	assign i_last = (i_q + FW'(1)) == tf_q;
	assign j_last = (j_q + FW'(1)) == rf_q;

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			i_q       <= '0;
			j_q       <= '0;
			ti_base_q <= '0;
			tj_base_q <= '0;
		end else if (cmd.cell_upd) begin
			left_q <= acc;
			diag_q <= above_q;
			if (j_last) begin
				j_q       <= '0;
				tj_base_q <= '0;
				i_q       <= i_q + FW'(1);
				ti_base_q <= ti_base_q + CW'(dim);
			end else begin
				j_q       <= j_q + FW'(1);
				tj_base_q <= tj_base_q + CW'(dim);
			end
		end
	end

	assign n_frames = {1'b0, tf_q} + {1'b0, rf_q};

	always_comb begin
		case (cmd.div_opnd)
			DIV_TEST: begin
				div_nd = DIV_NW'(test_cnt_q);
				div_dv = VW'(dim);
			end
			DIV_TRAIN: begin
				div_nd = DIV_NW'(train_cnt_q);
				div_dv = VW'(dim);
			end
			default: begin
				div_nd = DIV_NW'(acc) + DIV_NW'(n_frames >> 1);
				div_dv = VW'(n_frames);
			end
		endcase
	end

	dtwe_div #(.NW(DIV_NW), .VW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_nd),
		.divisor  (div_dv),
		.done     (div_done),
		.quo      (div_q),
		.rem      (div_r)
	);

	assign q_capped = (div_q > DIV_NW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : div_q[FW-1:0];

	always_comb begin
		if (test_cnt_q > cap || train_cnt_q > cap) status_c = STAT_TOO_LONG;
		else if (!test_closed_q || test_cnt_q == '0 || train_cnt_q == '0 ||
				t_rem_q || r_rem_q) status_c = STAT_UNUSABLE;
		else status_c = STAT_OK;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_tq) begin
			tf_q    <= q_capped;
			t_rem_q <= div_r != '0;
		end
		if (cmd.latch_rq) begin
			rf_q    <= q_capped;
			r_rem_q <= div_r != '0;
		end
		if (cmd.check) begin
			status_q <= status_c;
			dist_q   <= '0;
		end
		if (cmd.cell_upd && i_last && j_last && acc == COST_SAT) dist_q <= COST_SAT;
		if (cmd.latch_dist) dist_q <= div_q[DIST_W-1:0];
		if (cmd.load_out) begin
			out_dist_q   <= dist_q;
			out_tf_q     <= FRAMES_W'(tf_q);
			out_rf_q     <= FRAMES_W'(rf_q);
			out_status_q <= status_q;
		end
	end

	assign out_word = {4'b0000, out_status_q, out_rf_q, out_tf_q, out_dist_q};

	assign stat.div_done  = div_done;
	assign stat.grid_ok   = status_c == STAT_OK;
	assign stat.mac_done  = cmd.mac_run && (k_q == KW'(dim) + KW'(2));
	assign stat.sqrt_done = sqrt_done;
	assign stat.grid_last = i_last && j_last;
	assign stat.acc_sat   = acc == COST_SAT;
endmodule

@@ tb/dtw_euclidean_distance_test.sv @@
// Testbench for dtw_euclidean_distance: directed and random sequences checked against a DTW predictor.
module dtw_euclidean_distance_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dtwe_pkg::*;

	localparam int FRAMES_MAX = 256;
	localparam int DIM_MAX    = 16;
	localparam int STORE_SIZE = FRAMES_MAX * DIM_MAX;
	localparam int STALL_LIMIT = 60000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic [3:0]          pad;
		status_t             status;
		logic [FRAMES_W-1:0] train_frames;
		logic [FRAMES_W-1:0] test_frames;
		logic [DIST_W-1:0]   distance;
	} dtw_result_t;

	typedef struct {
		bit          train;
		logic [15:0] coeff;
		bit          last;
		bit          typed;
		dtw_result_t result;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [FDIM_W-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic s_axis_tuser;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	dtw_euclidean_distance u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
	);

	// predictor state
	logic [FDIM_W-1:0] fdim;
	logic [15:0] test_mem [STORE_SIZE];
	logic [15:0] train_mem [STORE_SIZE];
	int unsigned acc_row [FRAMES_MAX];
	int unsigned test_cnt, train_cnt;
	bit test_done;

	dtw_result_t distance_q[$];
	int mismatches;
	int stall_cycles;
	int send_idle, recv_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned dim_used();
		if (fdim == 0) return 1;
		if (fdim > DIM_MAX) return DIM_MAX;
		return fdim;
	endfunction

	function automatic void store_word(bit train, logic [15:0] v);
		int unsigned cap;
		cap = FRAMES_MAX * dim_used();
		if (train) begin
			if (train_cnt < cap) begin
				train_mem[train_cnt % STORE_SIZE] = v;
				train_cnt++;
			end else if (train_cnt == cap) train_cnt = cap + 1;
		end else begin
			if (test_cnt < cap) begin
				test_mem[test_cnt % STORE_SIZE] = v;
				test_cnt++;
			end else if (test_cnt == cap) test_cnt = cap + 1;
		end
	endfunction

	function automatic longint unsigned round_sqrt(longint unsigned s);
		longint unsigned r, b, x;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		x = s;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		if (s - r * r > r) r++;
		return r;
	endfunction

	function automatic int unsigned frame_cost(int unsigned ti, int unsigned tj, int unsigned d);
		longint unsigned sum;
		longint df;
		sum = 0;
		for (int unsigned k = 0; k < d; k++) begin
			df = longint'($signed(test_mem[(ti * d + k) % STORE_SIZE]))
				- longint'($signed(train_mem[(tj * d + k) % STORE_SIZE]));
			sum += longint'(df * df);
		end
		return int'(round_sqrt(sum));
	endfunction

	function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
		longint unsigned s;
		s = longint'(a) + longint'(b);
		return (s > 64'hFFFF_FFFF) ? COST_SAT : s[31:0];
	endfunction

	function automatic int unsigned warp_cost(int unsigned rows, int unsigned cols, int unsigned d);
		int unsigned diag, above, best, acc;
		for (int unsigned i = 0; i < rows; i++) begin
			diag = 0;
			for (int unsigned j = 0; j < cols; j++) begin
				above = acc_row[j];
				best = COST_SAT;
				if (i == 0 && j == 0) acc = 0;
				else begin
					if (i > 0 && above < best) best = above;
					if (j > 0 && acc_row[j-1] < best) best = acc_row[j-1];
					if (i > 0 && j > 0 && diag < best) best = diag;
					acc = sat_sum(frame_cost(i, j, d), best);
				end
				acc_row[j] = acc;
				diag = above;
			end
		end
		return acc_row[cols-1];
	endfunction

	// update state for one accepted word; returns 1 with the result on a train tlast
	function automatic bit predict_word(bit train, logic [15:0] v, bit last,
			output dtw_result_t res);
		int unsigned d, cap, tf, rf, total;
		longint unsigned n;
		res = '0;
		if (!train) begin
			if (test_done) begin
				test_cnt = 0;
				test_done = 0;
			end
			store_word(0, v);
			if (last) test_done = 1;
			return 0;
		end
		store_word(1, v);
		if (!last) return 0;
		d = dim_used();
		cap = FRAMES_MAX * d;
		tf = test_cnt / d;
		rf = train_cnt / d;
		if (tf > FRAMES_MAX) tf = FRAMES_MAX;
		if (rf > FRAMES_MAX) rf = FRAMES_MAX;
		res.status = STAT_OK;
		if (test_cnt > cap || train_cnt > cap) res.status = STAT_TOO_LONG;
		else if (!test_done || test_cnt == 0 || train_cnt == 0
				|| test_cnt % d != 0 || train_cnt % d != 0) res.status = STAT_UNUSABLE;
		else begin
			total = warp_cost(tf, rf, d);
			n = tf + rf;
			if (total == COST_SAT) res.distance = COST_SAT;
			else res.distance = 32'((longint'(total) + n / 2) / n);
		end
		train_cnt = 0;
		res.test_frames = tf[FRAMES_W-1:0];
		res.train_frames = rf[FRAMES_W-1:0];
		return 1;
	endfunction

	task automatic send_word(bit train, logic [15:0] v, bit last, bit typed = 0,
			dtw_result_t typed_res = '0);
		dtw_result_t res;
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		s_axis_tuser <= train;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		if (predict_word(train, v, last, res))
			distance_q.insert(distance_q.size(), typed ? typed_res : res);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (distance_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_dim(logic [FDIM_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		fdim = v;
	endtask

	function automatic logic [15:0] rand_coeff();
		if ($urandom_range(3) == 0) return 16'($urandom);
		return 16'($urandom_range(1024) - 512);
	endfunction

	task automatic send_run(bit train, int unsigned words, bit close);
		for (int unsigned k = 0; k < words; k++)
			send_word(train, rand_coeff(), close && k == words - 1);
	endtask

	// receiver: random stall and compare against the oldest expectation
	always @(posedge clk) begin
		dtw_result_t got, exp_r;
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (distance_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
			end else begin
				exp_r = distance_q.pop_front();
				if (got.distance !== exp_r.distance || got.test_frames !== exp_r.test_frames
						|| got.train_frames !== exp_r.train_frames
						|| got.status !== exp_r.status || got.pad !== exp_r.pad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp dist %h tf %0d rf %0d st %0d, got dist %h tf %0d rf %0d st %0d pad %h",
							exp_r.distance, exp_r.test_frames, exp_r.train_frames, exp_r.status,
							got.distance, got.test_frames, got.train_frames, got.status,
							got.pad);
				end
			end
		end
	end

	// watchdog: count cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL dtw_euclidean_distance");
			$finish;
		end
	end

	stim_row_t rows[$];

	function automatic stim_row_t row(bit train, logic [15:0] v, bit last, bit typed = 0,
			status_t st = STAT_OK, int tf = 0, int rf = 0);
		stim_row_t r;
		r.train = train;
		r.coeff = v;
		r.last = last;
		r.typed = typed;
		r.result = '0;
		r.result.status = st;
		r.result.test_frames = tf[FRAMES_W-1:0];
		r.result.train_frames = rf[FRAMES_W-1:0];
		return r;
	endfunction

	initial begin
		logic [FDIM_W-1:0] dims [6];
		int unsigned d, words, budget;
		bit fresh;
		dims = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd2, 5'd7};
		mismatches = 0;
		stall_cycles = 0;
		send_idle = 0;
		recv_idle = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		fdim = FDIM_RESET;
		test_cnt = 0;
		train_cnt = 0;
		test_done = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// at reset dim 13: a lone train word is a partial frame
		send_word(1, 16'h0042, 1, 1, row(1, 0, 1, 1, STAT_UNUSABLE, 0, 0).result);
		wait_idle();
		write_dim(5'd1);
		rows.insert(rows.size(), row(0, 16'h7FFF, 0));
		rows.insert(rows.size(), row(0, 16'h8000, 1));
		rows.insert(rows.size(), row(1, 16'h8000, 0));
		rows.insert(rows.size(), row(1, 16'h7FFF, 1));
		rows.insert(rows.size(), row(1, 16'h0000, 1));
		rows.insert(rows.size(), row(1, 16'hFFFF, 0));
		rows.insert(rows.size(), row(1, 16'h0001, 0));
		rows.insert(rows.size(), row(1, 16'h7FFF, 1));
		// new test sequence left open
		rows.insert(rows.size(), row(0, 16'h1234, 0));
		rows.insert(rows.size(), row(1, 16'h0005, 1, 1, STAT_UNUSABLE, 1, 1));
		rows.insert(rows.size(), row(0, 16'hFFFF, 1));
		rows.insert(rows.size(), row(1, 16'h0100, 1));
		rows.insert(rows.size(), row(0, 16'h5555, 0));
		rows.insert(rows.size(), row(0, 16'hAAAA, 1));
		rows.insert(rows.size(), row(1, 16'hAAAA, 0));
		rows.insert(rows.size(), row(1, 16'h5555, 1));
		foreach (rows[i])
			send_word(rows[i].train, rows[i].coeff, rows[i].last, rows[i].typed,
				rows[i].result);
		wait_idle();

		// store overflow on each side at dim 1, then a short valid grid
		send_run(0, 257, 1);
		send_run(1, 2, 1);
		send_run(0, 2, 1);
		send_run(1, 257, 1);
		send_run(1, 2, 1);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			send_idle = (p < 2) ? 32 : (p < 4) ? 62 : 0;
			recv_idle = (p < 2) ? 62 : (p < 4) ? 32 : 0;
			write_dim(dims[p]);
			d = dim_used();
			budget = 0;
			fresh = 1;
			while (budget < 45) begin
				if (fresh || $urandom_range(99) < 40) begin
					words = $urandom_range(1, 4) * d;
					if ($urandom_range(99) < 8) words++;
					send_run(0, words, $urandom_range(99) >= 6);
					budget += words;
					fresh = 0;
				end
				words = $urandom_range(1, 4) * d;
				if ($urandom_range(99) < 8) words++;
				send_run(1, words, 1);
				budget += words;
			end
			wait_idle();
		end

		if (mismatches == 0 && distance_q.size() == 0)
			$display("PASS dtw_euclidean_distance");
		else
			$display("FAIL dtw_euclidean_distance");
		$finish;
	end
endmodule
